@@ sv/cft_pkg.sv @@
// Shared constants, codes and types for the frustum cull tester.
// No dependencies; every other file but cft_ram takes names from here by scope.
`timescale 1ns / 1ps
`default_nettype none

package cft_pkg;

   localparam int NUM_PLANES  = 6;
   localparam int COORD_WIDTH = 32;
   localparam int FIELD_W     = 32;
   localparam int FRAC_BITS   = 16;
   localparam int INDEX_W     = 3;
   localparam int OP_W        = 2;
   localparam int VERDICT_W   = 2;
   localparam int CORNER_W    = 3;
   localparam int PLANE_AW    = $clog2(NUM_PLANES);
   localparam int PROD_W      = 2 * COORD_WIDTH;
   localparam int OFF_W       = COORD_WIDTH + 1;
   localparam int SUM_W       = 2 * COORD_WIDTH + 3;
   localparam int ENTRY_W     = 4 * COORD_WIDTH + CORNER_W;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE  = 2'd0,
      OP_BOX    = 2'd1,
      OP_SPHERE = 2'd2,
      OP_POINT  = 2'd3
   } op_type;

   localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE    = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_INTERSECTS = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_INSIDE     = 2'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_REJECT     = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT     = 2'd1;

   // one stored plane: corner-select bits, constant d and normal a, b, c
   typedef struct packed {
      logic [CORNER_W-1:0]           corner;
      logic signed [COORD_WIDTH-1:0] d;
      logic signed [COORD_WIDTH-1:0] c;
      logic signed [COORD_WIDTH-1:0] b;
      logic signed [COORD_WIDTH-1:0] a;
   } plane_type;

endpackage

`default_nettype wire

@@ sv/cft_if.sv @@
// Valid/ready channel interfaces for the request and response sides.
// Depends on cft_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cft_req_if;
   logic                               valid;
   logic                               ready;
   logic [cft_pkg::OP_W-1:0]           op;
   logic [cft_pkg::INDEX_W-1:0]        plane_index;
   logic signed [cft_pkg::FIELD_W-1:0] lo_x;
   logic signed [cft_pkg::FIELD_W-1:0] lo_y;
   logic signed [cft_pkg::FIELD_W-1:0] lo_z;
   logic signed [cft_pkg::FIELD_W-1:0] hi_x;
   logic signed [cft_pkg::FIELD_W-1:0] hi_y;
   logic signed [cft_pkg::FIELD_W-1:0] hi_z;
   logic signed [cft_pkg::FIELD_W-1:0] plane_offset;

   modport source (
      output valid, op, plane_index, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, plane_offset,
      input  ready
   );
   modport sink (
      input  valid, op, plane_index, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, plane_offset,
      output ready
   );
endinterface

interface cft_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [cft_pkg::VERDICT_W-1:0]  verdict;

   modport source (output valid, verdict, input ready);
   modport sink (input valid, verdict, output ready);
endinterface

`default_nettype wire

@@ sv/frustum_cull_tester_core.sv @@
// Frustum cull tester top level: plane store, dot-product pipeline, verdict.
// Depends on cft_pkg, cft_if (cft_req_if, cft_rsp_if) and cft_ram.
//
// Usage:
// The req_if channel carries one transaction per command. Op write stores a
// plane (normal a,b,c in lo_x/y/z, constant d in plane_offset) in slot
// plane_index and returns nothing; a slot at or beyond NUM_PLANES is dropped.
// Op box, sphere and point each return one verdict on rsp_if.
// Planes live in a small RAM with one read port; the block reads one plane a
// cycle and forms its dot product with three multipliers, then a wide sum.
// A box reads each plane twice (farthest and nearest corner); a sphere or
// point reads each plane once. A plane write leaves req_if ready.
// The verdict sits in an output register; the next command is accepted while
// it waits. If rsp_if stalls, a second verdict holds in the final state until
// the register frees, and req_if stays low meanwhile.
// Reset clears all planes to zero through per-slot valid bits (no clearing
// pass); unwritten planes read as zero.
`timescale 1ns / 1ps
`default_nettype none

module frustum_cull_tester_core (
   input  wire logic   clock,
   input  wire logic   reset,
   cft_req_if.sink     req_if,
   cft_rsp_if.source   rsp_if
);

   localparam int CW = cft_pkg::COORD_WIDTH;
   localparam int AW = cft_pkg::PLANE_AW;
   localparam logic [AW-1:0] LAST_PLANE = AW'(cft_pkg::NUM_PLANES - 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [AW-1:0] plane_ff, plane_in;
   logic          pass_ff, pass_in;

   cft_pkg::op_type      op_ff, op_in;
   logic signed [CW-1:0] lo_x_ff, lo_y_ff, lo_z_ff, hi_x_ff, hi_y_ff, hi_z_ff;

   logic [cft_pkg::NUM_PLANES-1:0] plane_valid_ff, plane_valid_in;

   logic req_fire;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   cft_pkg::plane_type wr_plane, rd_raw, rd_plane;

   // read token, aligned with RAM output
   logic rd_tok_ff, rd_pass_ff, rd_pvld_ff;

   // product stage
   logic                       prod_vld_ff, prod_pass_ff;
   logic signed [cft_pkg::PROD_W-1:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [cft_pkg::PROD_W-1:0] prod_x_in, prod_y_in, prod_z_in;
   logic signed [cft_pkg::OFF_W-1:0]  off_ff, off_in;
   logic signed [CW-1:0] opnd_x, opnd_y, opnd_z, extra;
   logic [cft_pkg::CORNER_W-1:0] sel_lo;

   logic signed [cft_pkg::SUM_W-1:0] plane_dist;
   logic dist_neg, dist_zero;

   logic flag_out_ff, flag_out_in, flag_cut_ff, flag_cut_in;

   logic                          rsp_vld_ff, rsp_vld_in;
   logic [cft_pkg::VERDICT_W-1:0] rsp_verdict_ff, rsp_verdict_in, verdict;
   logic rsp_free;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign rsp_free     = !rsp_vld_ff || rsp_if.ready;

   // ---------------- plane store ----------------
   assign wr_en   = req_fire && (req_if.op == cft_pkg::OP_WRITE)
                    && (int'(req_if.plane_index) < cft_pkg::NUM_PLANES);
   assign wr_addr = AW'(req_if.plane_index);

   always_comb begin
      wr_plane.a      = $signed(req_if.lo_x[CW-1:0]);
      wr_plane.b      = $signed(req_if.lo_y[CW-1:0]);
      wr_plane.c      = $signed(req_if.lo_z[CW-1:0]);
      wr_plane.d      = $signed(req_if.plane_offset[CW-1:0]);
      wr_plane.corner = {req_if.lo_z[CW-1], req_if.lo_y[CW-1], req_if.lo_x[CW-1]};
   end

   always_comb begin
      plane_valid_in = plane_valid_ff;
      if (wr_en) begin
         plane_valid_in[wr_addr] = 1'b1;
      end
   end

   cft_ram #(
      .WIDTH (cft_pkg::ENTRY_W),
      .DEPTH (cft_pkg::NUM_PLANES)
   ) u_plane_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_plane),
      .rd_addr (plane_ff),
      .rd_data (rd_raw)
   );

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      plane_in = plane_ff;
      pass_in  = pass_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_if.op != cft_pkg::OP_WRITE)) begin
               state_in = ST_ISSUE;
               plane_in = '0;
               pass_in  = 1'b0;
            end
         end
         ST_ISSUE: begin
            // box: far pass then near pass on the same plane
            if ((op_ff == cft_pkg::OP_BOX) && !pass_ff) begin
               pass_in = 1'b1;
            end else begin
               pass_in = 1'b0;
               if (plane_ff == LAST_PLANE) begin
                  plane_in = '0;
                  state_in = ST_DRAIN;
               end else begin
                  plane_in = plane_ff + 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            if (!rd_tok_ff && !prod_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign op_in = cft_pkg::op_type'(req_if.op);

   // ---------------- product stage ----------------
   always_comb begin
      // unwritten slots read as an all-zero plane
      rd_plane = rd_pvld_ff ? rd_raw : '0;
      sel_lo   = rd_plane.corner ^ {cft_pkg::CORNER_W{rd_pass_ff}};
      if (op_ff == cft_pkg::OP_BOX) begin
         opnd_x = sel_lo[0] ? lo_x_ff : hi_x_ff;
         opnd_y = sel_lo[1] ? lo_y_ff : hi_y_ff;
         opnd_z = sel_lo[2] ? lo_z_ff : hi_z_ff;
      end else begin
         opnd_x = lo_x_ff;
         opnd_y = lo_y_ff;
         opnd_z = lo_z_ff;
      end
      extra     = (op_ff == cft_pkg::OP_SPHERE) ? hi_x_ff : '0;
      prod_x_in = rd_plane.a * opnd_x;
      prod_y_in = rd_plane.b * opnd_y;
      prod_z_in = rd_plane.c * opnd_z;
      off_in    = cft_pkg::OFF_W'(rd_plane.d) + cft_pkg::OFF_W'(extra);
   end

   // ---------------- sum and sign ----------------
   always_comb begin
      plane_dist = cft_pkg::SUM_W'(prod_x_ff) + cft_pkg::SUM_W'(prod_y_ff)
                 + cft_pkg::SUM_W'(prod_z_ff)
                 + (cft_pkg::SUM_W'(off_ff) <<< cft_pkg::FRAC_BITS);
      dist_neg  = plane_dist[cft_pkg::SUM_W-1];
      dist_zero = (plane_dist == '0);
   end

   always_comb begin
      flag_out_in = flag_out_ff;
      flag_cut_in = flag_cut_ff;
      if (req_fire) begin
         flag_out_in = 1'b0;
         flag_cut_in = 1'b0;
      end else if (prod_vld_ff) begin
         case (op_ff)
            cft_pkg::OP_BOX: begin
               if (dist_neg && !prod_pass_ff) flag_out_in = 1'b1;
               if (dist_neg && prod_pass_ff)  flag_cut_in = 1'b1;
            end
            cft_pkg::OP_SPHERE: begin
               if (dist_neg || dist_zero) flag_out_in = 1'b1;
            end
            default: begin
               if (dist_neg) flag_out_in = 1'b1;
            end
         endcase
      end
   end

   // ---------------- response register ----------------
   always_comb begin
      if (op_ff == cft_pkg::OP_BOX) begin
         verdict = flag_out_ff ? cft_pkg::VERDICT_OUTSIDE :
                   flag_cut_ff ? cft_pkg::VERDICT_INTERSECTS : cft_pkg::VERDICT_INSIDE;
      end else begin
         verdict = flag_out_ff ? cft_pkg::VERDICT_REJECT : cft_pkg::VERDICT_ACCEPT;
      end
      rsp_vld_in     = rsp_vld_ff;
      rsp_verdict_in = rsp_verdict_ff;
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_vld_in     = 1'b1;
         rsp_verdict_in = verdict;
      end else if (rsp_if.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   assign rsp_if.valid   = rsp_vld_ff;
   assign rsp_if.verdict = rsp_verdict_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         plane_ff       <= '0;
         pass_ff        <= 1'b0;
         plane_valid_ff <= '0;
         rd_tok_ff      <= 1'b0;
         prod_vld_ff    <= 1'b0;
         rsp_vld_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         plane_ff       <= plane_in;
         pass_ff        <= pass_in;
         plane_valid_ff <= plane_valid_in;
         rd_tok_ff      <= (state_ff == ST_ISSUE);
         prod_vld_ff    <= rd_tok_ff;
         rsp_vld_ff     <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= op_in;
         lo_x_ff <= $signed(req_if.lo_x[CW-1:0]);
         lo_y_ff <= $signed(req_if.lo_y[CW-1:0]);
         lo_z_ff <= $signed(req_if.lo_z[CW-1:0]);
         hi_x_ff <= $signed(req_if.hi_x[CW-1:0]);
         hi_y_ff <= $signed(req_if.hi_y[CW-1:0]);
         hi_z_ff <= $signed(req_if.hi_z[CW-1:0]);
      end
      rd_pass_ff     <= pass_ff;
      rd_pvld_ff     <= plane_valid_ff[plane_ff];
      prod_pass_ff   <= rd_pass_ff;
      prod_x_ff      <= prod_x_in;
      prod_y_ff      <= prod_y_in;
      prod_z_ff      <= prod_z_in;
      off_ff         <= off_in;
      flag_out_ff    <= flag_out_in;
      flag_cut_ff    <= flag_cut_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

`ifndef ASSERT_OFF
   a_prod_follows_read: assert property (@(posedge clock) disable iff (reset)
      prod_vld_ff |-> $past(rd_tok_ff))
      else $error("product stage valid without a read the cycle before");

   a_done_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (!rd_tok_ff && !prod_vld_ff))
      else $error("verdict formed while dot products still in flight");

   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> plane_valid_ff[$past(wr_addr)])
      else $error("plane write did not mark its slot valid");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the final state");

   a_no_issue_while_busy: assert property (@(posedge clock) disable iff (reset)
      (rd_tok_ff || prod_vld_ff) |-> !req_if.ready)
      else $error("new command accepted while planes are being read");
`endif

endmodule

`default_nettype wire

@@ sv/cft_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for frustum_cull_tester_core: plane writes, box, sphere and point tests.
// Depends on cft_pkg and cft_if from the RTL; holds its own fixed-point predictor of the verdicts.
`timescale 1ns / 1ps

module tb;

   localparam int NUM_PLANES = cft_pkg::NUM_PLANES;
   localparam int FIELD_W    = cft_pkg::FIELD_W;
   localparam int INDEX_W    = cft_pkg::INDEX_W;
   localparam int VERDICT_W  = cft_pkg::VERDICT_W;
   localparam int CORNER_W   = cft_pkg::CORNER_W;

   typedef cft_pkg::op_type    op_type;
   typedef cft_pkg::plane_type plane_type;

   localparam op_type OP_WRITE  = cft_pkg::OP_WRITE;
   localparam op_type OP_BOX    = cft_pkg::OP_BOX;
   localparam op_type OP_SPHERE = cft_pkg::OP_SPHERE;
   localparam op_type OP_POINT  = cft_pkg::OP_POINT;

   localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE    = cft_pkg::VERDICT_OUTSIDE;
   localparam logic [VERDICT_W-1:0] VERDICT_INTERSECTS = cft_pkg::VERDICT_INTERSECTS;
   localparam logic [VERDICT_W-1:0] VERDICT_INSIDE     = cft_pkg::VERDICT_INSIDE;
   localparam logic [VERDICT_W-1:0] VERDICT_REJECT     = cft_pkg::VERDICT_REJECT;
   localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT     = cft_pkg::VERDICT_ACCEPT;

   localparam int Q_ONE          = 65536;
   localparam int COORD_SPAN     = 64 * Q_ONE;
   localparam int N_DIRECTED     = 25;
   localparam int RANDOM_ITEMS   = 1800;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 2 * NUM_PLANES + 8;
   localparam logic signed [FIELD_W-1:0] MAXV = 32'sh7fff_ffff;
   localparam logic signed [FIELD_W-1:0] MINV = 32'sh8000_0000;

   typedef struct packed {
      op_type                     op;
      logic [INDEX_W-1:0]         slot;
      logic signed [FIELD_W-1:0]  lo_x;
      logic signed [FIELD_W-1:0]  lo_y;
      logic signed [FIELD_W-1:0]  lo_z;
      logic signed [FIELD_W-1:0]  hi_x;
      logic signed [FIELD_W-1:0]  hi_y;
      logic signed [FIELD_W-1:0]  hi_z;
      logic signed [FIELD_W-1:0]  offset;
      logic                       typed;
      logic [VERDICT_W-1:0]       verdict;
   } cull_cmd_type;

   logic clock;
   logic reset;

   cft_req_if req_if ();
   cft_rsp_if rsp_if ();

   frustum_cull_tester_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   plane_type            frustum_planes [NUM_PLANES];
   cull_cmd_type         directed_rows [N_DIRECTED];
   logic [VERDICT_W-1:0] pending_verdicts [$];

   bit steady_sender;
   int mismatch_count;
   int verdicts_checked;
   int idle_cycles;
   int writes_applied, writes_dropped;
   int box_tally [3];
   int sphere_count, sphere_accepts, point_count, point_accepts;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Sign of a*x + b*y + c*z + d + extra, exact in Q32.32.
   function automatic int plane_side(plane_type p, logic signed [FIELD_W-1:0] x,
                                     logic signed [FIELD_W-1:0] y,
                                     logic signed [FIELD_W-1:0] z,
                                     logic signed [FIELD_W-1:0] extra);
      logic signed [95:0] acc;
      longint na, nb, nc, nd, px, py, pz, pe;
      na = longint'(p.a);
      nb = longint'(p.b);
      nc = longint'(p.c);
      nd = longint'(p.d);
      px = longint'(x);
      py = longint'(y);
      pz = longint'(z);
      pe = longint'(extra);
      acc = 96'(na) * 96'(px) + 96'(nb) * 96'(py) + 96'(nc) * 96'(pz)
          + 96'(nd + pe) * 96'sd65536;
      if (acc < 0) return -1;
      if (acc == 0) return 0;
      return 1;
   endfunction

   // Update the plane store and return 1 when the command yields a verdict.
   function automatic bit predict_cull(input cull_cmd_type c, output logic [VERDICT_W-1:0] v);
      bit outside, cut;
      logic [CORNER_W-1:0] s;
      v = VERDICT_REJECT;
      case (c.op)
         OP_WRITE: begin
            if (c.slot < NUM_PLANES) begin
               frustum_planes[c.slot].a      = c.lo_x;
               frustum_planes[c.slot].b      = c.lo_y;
               frustum_planes[c.slot].c      = c.lo_z;
               frustum_planes[c.slot].d      = c.offset;
               frustum_planes[c.slot].corner = {c.lo_z < 0, c.lo_y < 0, c.lo_x < 0};
            end
            return 1'b0;
         end
         OP_BOX: begin
            outside = 1'b0;
            cut     = 1'b0;
            for (int i = 0; i < NUM_PLANES; i++) begin
               s = frustum_planes[i].corner;
               if (plane_side(frustum_planes[i], s[0] ? c.lo_x : c.hi_x, s[1] ? c.lo_y : c.hi_y,
                              s[2] ? c.lo_z : c.hi_z, 0) < 0)
                  outside = 1'b1;
               if (plane_side(frustum_planes[i], s[0] ? c.hi_x : c.lo_x, s[1] ? c.hi_y : c.lo_y,
                              s[2] ? c.hi_z : c.lo_z, 0) < 0)
                  cut = 1'b1;
            end
            v = outside ? VERDICT_OUTSIDE : (cut ? VERDICT_INTERSECTS : VERDICT_INSIDE);
         end
         OP_SPHERE: begin
            v = VERDICT_ACCEPT;
            for (int i = 0; i < NUM_PLANES; i++)
               if (plane_side(frustum_planes[i], c.lo_x, c.lo_y, c.lo_z, c.hi_x) <= 0)
                  v = VERDICT_REJECT;
         end
         default: begin
            v = VERDICT_ACCEPT;
            for (int i = 0; i < NUM_PLANES; i++)
               if (plane_side(frustum_planes[i], c.lo_x, c.lo_y, c.lo_z, 0) < 0)
                  v = VERDICT_REJECT;
         end
      endcase
      return 1'b1;
   endfunction

   function automatic logic signed [FIELD_W-1:0] random_coord();
      case ($urandom_range(9))
         0: return $urandom;
         1: begin
            case ($urandom_range(5))
               0: return MINV;
               1: return MAXV;
               2: return 0;
               3: return -1;
               4: return Q_ONE;
               default: return -Q_ONE;
            endcase
         end
         default: return $signed($urandom_range(0, 2 * COORD_SPAN)) - COORD_SPAN;
      endcase
   endfunction

   function automatic logic signed [FIELD_W-1:0] random_normal();
      if ($urandom_range(9) < 8)
         return $signed($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
      return random_coord();
   endfunction

   function automatic int random_extent(bit flip);
      int size;
      size = $urandom_range(0, 16 * Q_ONE);
      return flip ? -size : size;
   endfunction

   // Mostly well-formed frusta and objects near them; unused fields carry noise.
   function automatic cull_cmd_type random_cmd();
      cull_cmd_type c;
      int pick;
      c.lo_x    = random_coord();
      c.lo_y    = random_coord();
      c.lo_z    = random_coord();
      c.hi_x    = random_coord();
      c.hi_y    = random_coord();
      c.hi_z    = random_coord();
      c.offset  = random_coord();
      c.slot    = INDEX_W'($urandom_range(0, 7));
      c.typed   = 1'b0;
      c.verdict = VERDICT_REJECT;
      pick = $urandom_range(99);
      if (pick < 15) begin
         c.op   = OP_WRITE;
         c.slot = INDEX_W'(($urandom_range(9) == 0) ? $urandom_range(NUM_PLANES, 7)
                                                    : $urandom_range(0, NUM_PLANES - 1));
         c.lo_x = random_normal();
         c.lo_y = random_normal();
         c.lo_z = random_normal();
         if ($urandom_range(9) < 7)
            c.offset = $urandom_range(0, 48 * Q_ONE);
      end else if (pick < 50) begin
         c.op   = OP_BOX;
         c.hi_x = c.lo_x + random_extent($urandom_range(9) == 0);
         c.hi_y = c.lo_y + random_extent($urandom_range(9) == 0);
         c.hi_z = c.lo_z + random_extent($urandom_range(9) == 0);
      end else if (pick < 75) begin
         c.op = OP_SPHERE;
         if ($urandom_range(9) < 8)
            c.hi_x = $urandom_range(0, 32 * Q_ONE);
      end else begin
         c.op = OP_POINT;
      end
      return c;
   endfunction

   // Offer one transaction, with random idle cycles ahead of it, and predict on acceptance.
   task automatic send_cmd(input cull_cmd_type c);
      logic [VERDICT_W-1:0] v;
      while (!steady_sender && $urandom_range(99) < 32) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.op           <= c.op;
      req_if.plane_index  <= c.slot;
      req_if.lo_x         <= c.lo_x;
      req_if.lo_y         <= c.lo_y;
      req_if.lo_z         <= c.lo_z;
      req_if.hi_x         <= c.hi_x;
      req_if.hi_y         <= c.hi_y;
      req_if.hi_z         <= c.hi_z;
      req_if.plane_offset <= c.offset;
      do @(posedge clock); while (!req_if.ready);
      if (predict_cull(c, v))
         pending_verdicts.push_back(c.typed ? c.verdict : v);
      case (c.op)
         OP_WRITE: begin
            if (c.slot < NUM_PLANES) writes_applied++;
            else writes_dropped++;
         end
         OP_BOX: box_tally[v]++;
         OP_SPHERE: begin
            sphere_count++;
            sphere_accepts += int'(v == VERDICT_ACCEPT);
         end
         default: begin
            point_count++;
            point_accepts += int'(v == VERDICT_ACCEPT);
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: verdict mismatch (%s): expected %0d, got %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         verdicts_checked++;
         if (pending_verdicts.size() == 0)
            report_mismatch("nothing pending", -1, int'(rsp_if.verdict));
         else if (rsp_if.verdict !== pending_verdicts[0]) begin
            report_mismatch("wrong value", int'(pending_verdicts[0]), int'(rsp_if.verdict));
            void'(pending_verdicts.pop_front());
         end else
            void'(pending_verdicts.pop_front());
      end
   end

   // Receiver: random stalls, one long hold-off to back the block up, then a steady window.
   initial begin
      int cycle_count;
      cycle_count = 0;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (cycle_count >= 2000 && cycle_count < 2400)
            rsp_if.ready <= 1'b0;
         else if (cycle_count >= 6000 && cycle_count < 10000)
            rsp_if.ready <= 1'b1;
         else
            rsp_if.ready <= ($urandom_range(99) >= 32);
         @(posedge clock);
         cycle_count++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog: no transaction for %0d cycles", $time, idle_cycles);
         $display("FAIL");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      cull_cmd_type cmd;
      int n;
      for (int i = 0; i < NUM_PLANES; i++)
         frustum_planes[i] = '0;
      idle_cycles          = 0;
      steady_sender        = 1'b0;
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.op           <= OP_WRITE;
      req_if.plane_index  <= '0;
      req_if.lo_x         <= '0;
      req_if.lo_y         <= '0;
      req_if.lo_z         <= '0;
      req_if.hi_x         <= '0;
      req_if.hi_y         <= '0;
      req_if.hi_z         <= '0;
      req_if.plane_offset <= '0;

      // op, slot, lo x/y/z, hi x/y/z, offset, typed, verdict
      directed_rows[0]  = '{OP_BOX, 3'd0, MINV, MINV, MINV, MAXV, MAXV, MAXV, 0, 1'b1,
                            VERDICT_INSIDE};
      directed_rows[1]  = '{OP_SPHERE, 3'd0, 0, 0, 0, 1, 0, 0, 0, 1'b1, VERDICT_ACCEPT};
      directed_rows[2]  = '{OP_SPHERE, 3'd5, MAXV, MAXV, MAXV, 0, MINV, MINV, MINV, 1'b1,
                            VERDICT_REJECT};
      directed_rows[3]  = '{OP_SPHERE, 3'd7, MINV, MINV, MINV, MINV, MAXV, MAXV, MAXV, 1'b1,
                            VERDICT_REJECT};
      directed_rows[4]  = '{OP_POINT, 3'd0, MINV, MINV, MINV, 0, 0, 0, 0, 1'b1, VERDICT_ACCEPT};
      // write to an absent slot: must leave every plane at zero
      directed_rows[5]  = '{OP_WRITE, 3'd7, Q_ONE, 0, 0, 0, 0, 0, MINV, 1'b0, VERDICT_REJECT};
      directed_rows[6]  = '{OP_POINT, 3'd3, MAXV, MINV, 0, 0, 0, 0, 0, 1'b1, VERDICT_ACCEPT};
      directed_rows[7]  = '{OP_WRITE, 3'd0, Q_ONE, 0, 0, 0, 0, 0, 0, 1'b0, VERDICT_REJECT};
      directed_rows[8]  = '{OP_POINT, 3'd0, -1, 0, 0, 0, 0, 0, 0, 1'b1, VERDICT_REJECT};
      directed_rows[9]  = '{OP_POINT, 3'd0, 0, MINV, MAXV, 0, 0, 0, 0, 1'b1, VERDICT_ACCEPT};
      directed_rows[10] = '{OP_WRITE, 3'd1, -Q_ONE, 0, 0, 0, 0, 0, 10 * Q_ONE, 1'b0,
                            VERDICT_REJECT};
      directed_rows[11] = '{OP_BOX, 3'd0, -Q_ONE, MINV, MINV, 5 * Q_ONE, MAXV, MAXV, 0, 1'b0,
                            VERDICT_REJECT};
      directed_rows[12] = '{OP_BOX, 3'd0, 2 * Q_ONE, 0, 0, 3 * Q_ONE, 0, 0, 0, 1'b0,
                            VERDICT_REJECT};
      directed_rows[13] = '{OP_BOX, 3'd0, 11 * Q_ONE, 0, 0, 12 * Q_ONE, 0, 0, 0, 1'b0,
                            VERDICT_REJECT};
      // swapped bounds are taken as given
      directed_rows[14] = '{OP_BOX, 3'd0, 5 * Q_ONE, 0, 0, -Q_ONE, 0, 0, 0, 1'b0,
                            VERDICT_REJECT};
      // sphere just touching the plane, then just crossing it
      directed_rows[15] = '{OP_SPHERE, 3'd0, -Q_ONE, 0, 0, Q_ONE, 0, 0, 0, 1'b0,
                            VERDICT_REJECT};
      directed_rows[16] = '{OP_SPHERE, 3'd0, -Q_ONE, 0, 0, Q_ONE + 1, 0, 0, 0, 1'b0,
                            VERDICT_REJECT};
      directed_rows[17] = '{OP_WRITE, 3'd2, 0, MINV, MAXV, 0, 0, 0, MAXV, 1'b0, VERDICT_REJECT};
      directed_rows[18] = '{OP_WRITE, 3'd5, MINV, MINV, MINV, 0, 0, 0, MINV, 1'b0,
                            VERDICT_REJECT};
      directed_rows[19] = '{OP_WRITE, 3'd6, MAXV, MAXV, MAXV, 0, 0, 0, MAXV, 1'b0,
                            VERDICT_REJECT};
      directed_rows[20] = '{OP_BOX, 3'd0, MINV, MINV, MINV, MAXV, MAXV, MAXV, 0, 1'b0,
                            VERDICT_REJECT};
      directed_rows[21] = '{OP_BOX, 3'd0, 0, -Q_ONE, Q_ONE, Q_ONE, Q_ONE, 2 * Q_ONE, 0, 1'b0,
                            VERDICT_REJECT};
      directed_rows[22] = '{OP_SPHERE, 3'd0, MAXV, MAXV, MAXV, MAXV, 0, 0, 0, 1'b0,
                            VERDICT_REJECT};
      directed_rows[23] = '{OP_POINT, 3'd0, MAXV, MAXV, MAXV, 0, 0, 0, 0, 1'b0, VERDICT_REJECT};
      directed_rows[24] = '{OP_POINT, 3'd0, 0, 0, 0, 0, 0, 0, 0, 1'b0, VERDICT_REJECT};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++)
         send_cmd(directed_rows[i]);

      n = 0;
      while (n < RANDOM_ITEMS) begin
         cmd = random_cmd();
         steady_sender = (n >= 900 && n < 1200);
         send_cmd(cmd);
         // writes to absent slots are ignored by the block; do not count them
         if (!(cmd.op == OP_WRITE && cmd.slot >= NUM_PLANES))
            n++;
      end
      req_if.valid <= 1'b0;

      while (pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("coverage: %0d plane writes (+%0d to absent slots), boxes out/cut/in %0d/%0d/%0d",
               writes_applied, writes_dropped, box_tally[0], box_tally[1], box_tally[2]);
      $display("coverage: spheres %0d (%0d accepted), points %0d (%0d accepted), %0d checked",
               sphere_count, sphere_accepts, point_count, point_accepts, verdicts_checked);
      if (mismatch_count == 0 && pending_verdicts.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
